// File: design/bnmp_pkg.sv
// ----------------------------------------------------------------------------
// bnmp_pkg
// Shared types, register map, reset values and helpers for the integer
// batch-norm and max-pool block.
// ----------------------------------------------------------------------------
package bnmp_pkg;

  // default geometry
  localparam int CHANNELS_DEF    = 16;
  localparam int POSITIONS_DEF   = 199;
  localparam int POOL_WINDOW_DEF = 3;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CH_CNT_W = 4;
  localparam int POS_W    = 8;
  localparam int PHASE_W  = 2;
  localparam int PARAM_W  = 8;
  localparam int TDATA_W  = 24;

  // divider
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_SCALE_LO  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_HI  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MEAN_LO   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MEAN_HI   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_LO = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_HI = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DENOM_LO  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DENOM_HI  = 3'd7;

  localparam logic [CFG_DATA_W-1:0] SCALE_RST  = 64'h0101_0101_0101_0101;
  localparam logic [CFG_DATA_W-1:0] MEAN_RST   = 64'h0;
  localparam logic [CFG_DATA_W-1:0] OFFSET_RST = 64'h0;
  localparam logic [CFG_DATA_W-1:0] DENOM_RST  = 64'h0101_0101_0101_0101;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_POST
  } bnmp_state_t;

  // signed 8-bit per-channel value out of a lo/hi register pair
  function automatic logic signed [PARAM_W-1:0] chan_byte(
    input logic [CFG_DATA_W-1:0] lo,
    input logic [CFG_DATA_W-1:0] hi,
    input logic [CH_CNT_W-1:0]   ch
  );
    logic [CFG_DATA_W-1:0] sel;
    sel = ch[3] ? hi : lo;
    return $signed(sel[8*ch[2:0] +: PARAM_W]);
  endfunction

endpackage

// File: design/batchnorm_maxpool_int16.sv
// A sample beat inside a whole pooling window passes through the multiply,
// setup, 16-step restoring divider and update steps before its result can reach
// the output register; no new sample is taken until that update step is done.
// A stalled output holds the update step; leftover positions are accepted in idle.
// Reset (rst, synchronous): clears counters, sequencer, output valid and the
// config registers to their defaults; the running maxima are not cleared.
// ----------------------------------------------------------------------------
// batchnorm_maxpool_int16
// Per-channel integer batch normalization with a running 1-D max pool over
// groups of positions, using one multiplier and one shared serial divider.
// ----------------------------------------------------------------------------
module batchnorm_maxpool_int16 #(
  parameter int CHANNELS    = bnmp_pkg::CHANNELS_DEF,
  parameter int POSITIONS   = bnmp_pkg::POSITIONS_DEF,
  parameter int POOL_WINDOW = bnmp_pkg::POOL_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bnmp_pkg::SAMPLE_W-1:0]       s_tdata,  // [15:0] sample
  input  logic                                s_tuser,  // [0] frame_start
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bnmp_pkg::TDATA_W-1:0]        m_tdata,  // [15:0] pooled_value, [19:16] channel
  output logic                                m_tlast,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bnmp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bnmp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bnmp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int GROUPS = POSITIONS / POOL_WINDOW;
  localparam int USED   = GROUPS * POOL_WINDOW;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int SW = bnmp_pkg::SAMPLE_W;
  localparam int PW = bnmp_pkg::PARAM_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [bnmp_pkg::CFG_DATA_W-1:0] scale_lo, scale_hi, mean_lo, mean_hi;
  logic [bnmp_pkg::CFG_DATA_W-1:0] offset_lo, offset_hi, denom_lo, denom_hi;
  logic                            cfg_wr;
  logic [bnmp_pkg::REG_IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[bnmp_pkg::CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_lo  <= bnmp_pkg::SCALE_RST;
      scale_hi  <= bnmp_pkg::SCALE_RST;
      mean_lo   <= bnmp_pkg::MEAN_RST;
      mean_hi   <= bnmp_pkg::MEAN_RST;
      offset_lo <= bnmp_pkg::OFFSET_RST;
      offset_hi <= bnmp_pkg::OFFSET_RST;
      denom_lo  <= bnmp_pkg::DENOM_RST;
      denom_hi  <= bnmp_pkg::DENOM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bnmp_pkg::REG_SCALE_LO:  scale_lo  <= pwdata;
        bnmp_pkg::REG_SCALE_HI:  scale_hi  <= pwdata;
        bnmp_pkg::REG_MEAN_LO:   mean_lo   <= pwdata;
        bnmp_pkg::REG_MEAN_HI:   mean_hi   <= pwdata;
        bnmp_pkg::REG_OFFSET_LO: offset_lo <= pwdata;
        bnmp_pkg::REG_OFFSET_HI: offset_hi <= pwdata;
        bnmp_pkg::REG_DENOM_LO:  denom_lo  <= pwdata;
        bnmp_pkg::REG_DENOM_HI:  denom_hi  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bnmp_pkg::REG_SCALE_LO:  prdata = scale_lo;
      bnmp_pkg::REG_SCALE_HI:  prdata = scale_hi;
      bnmp_pkg::REG_MEAN_LO:   prdata = mean_lo;
      bnmp_pkg::REG_MEAN_HI:   prdata = mean_hi;
      bnmp_pkg::REG_OFFSET_LO: prdata = offset_lo;
      bnmp_pkg::REG_OFFSET_HI: prdata = offset_hi;
      bnmp_pkg::REG_DENOM_LO:  prdata = denom_lo;
      bnmp_pkg::REG_DENOM_HI:  prdata = denom_hi;
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // frame counters, updated on every accepted beat
  // --------------------------------------------------------------------------
  logic [bnmp_pkg::CH_CNT_W-1:0] ch_cnt;
  logic [bnmp_pkg::POS_W-1:0]    pos_cnt;
  logic [bnmp_pkg::PHASE_W-1:0]  phase;
  logic [bnmp_pkg::CH_CNT_W-1:0] cur_ch;
  logic [bnmp_pkg::POS_W-1:0]    cur_pos;
  logic [bnmp_pkg::PHASE_W-1:0]  cur_phase;
  logic                          in_use, in_emit, in_last, in_beat;
  logic                          ch_wrap, pos_wrap;
  logic [bnmp_pkg::POS_W-1:0]    pos_inc;

  assign in_beat   = s_tvalid && s_tready;
  assign cur_ch    = s_tuser ? '0 : ch_cnt;
  assign cur_pos   = s_tuser ? '0 : pos_cnt;
  assign cur_phase = s_tuser ? '0 : phase;
  assign in_use    = cur_pos < bnmp_pkg::POS_W'(USED);
  assign in_emit   = in_use && (cur_phase == bnmp_pkg::PHASE_W'(POOL_WINDOW - 1));
  assign in_last   = in_emit && (cur_pos == bnmp_pkg::POS_W'(USED - 1))
                     && (cur_ch == bnmp_pkg::CH_CNT_W'(CHANNELS - 1));
  assign ch_wrap   = cur_ch == bnmp_pkg::CH_CNT_W'(CHANNELS - 1);
  assign pos_inc   = cur_pos + 1'b1;
  assign pos_wrap  = pos_inc == bnmp_pkg::POS_W'(POSITIONS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt  <= '0;
      pos_cnt <= '0;
      phase   <= '0;
    end else if (in_beat) begin
      if (ch_wrap) begin
        ch_cnt <= '0;
        if (pos_wrap) begin
          pos_cnt <= '0;
          phase   <= '0;
        end else begin
          pos_cnt <= pos_inc;
          phase   <= (cur_phase == bnmp_pkg::PHASE_W'(POOL_WINDOW - 1)) ? '0
                     : cur_phase + 1'b1;
        end
      end else begin
        ch_cnt  <= cur_ch + 1'b1;
        pos_cnt <= cur_pos;
        phase   <= cur_phase;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  bnmp_pkg::bnmp_state_t          state, state_next;
  logic [bnmp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                           emit_q, last_q, first_q;
  logic                           out_free, post_done;

  assign out_free  = !m_tvalid || m_tready;
  assign post_done = !emit_q || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bnmp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      bnmp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && in_use) state_next = bnmp_pkg::ST_MUL;
      end
      bnmp_pkg::ST_MUL:  state_next = bnmp_pkg::ST_PREP;
      bnmp_pkg::ST_PREP: state_next = bnmp_pkg::ST_DIV;
      bnmp_pkg::ST_DIV: begin
        if (div_cnt == bnmp_pkg::DIV_CNT_W'(bnmp_pkg::DIV_STEPS - 1)) begin
          state_next = bnmp_pkg::ST_POST;
        end
      end
      bnmp_pkg::ST_POST: begin
        if (post_done) state_next = bnmp_pkg::ST_IDLE;
      end
      default: state_next = bnmp_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath: subtract and scale, serial divide, offset and running max
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]          x_q, p_q;
  logic [bnmp_pkg::CH_CNT_W-1:0] ch_q;
  logic signed [PW-1:0]          mean_c, scale_c, offset_c, denom_c;
  logic signed [SW-1:0]          diff;
  logic signed [SW+PW-1:0]       prod;
  logic [SW-1:0]                 dvd;
  logic [PW-1:0]                 dsr, rem;
  logic [PW:0]                   trial;
  logic                          neg_q, zero_q;
  logic signed [SW-1:0]          quo, norm, new_max, rmax_rd;
  logic signed [SW-1:0]          running_max [CHANNELS];

  assign mean_c   = bnmp_pkg::chan_byte(mean_lo, mean_hi, ch_q);
  assign scale_c  = bnmp_pkg::chan_byte(scale_lo, scale_hi, ch_q);
  assign offset_c = bnmp_pkg::chan_byte(offset_lo, offset_hi, ch_q);
  assign denom_c  = bnmp_pkg::chan_byte(denom_lo, denom_hi, ch_q);

  assign diff  = x_q - SW'(mean_c);
  assign prod  = diff * scale_c;
  assign trial = {rem, dvd[SW-1]};

  // quotient of -32768 by -1 wraps back to -32768 here
  assign quo     = zero_q ? '0 : (neg_q ? -$signed(dvd) : $signed(dvd));
  assign norm    = quo + SW'(offset_c);
  assign new_max = (first_q || norm > rmax_rd) ? norm : rmax_rd;

  always_ff @(posedge clk) begin
    case (state)
      bnmp_pkg::ST_IDLE: begin
        x_q     <= $signed(s_tdata);
        ch_q    <= cur_ch;
        emit_q  <= in_emit;
        last_q  <= in_last;
        first_q <= cur_phase == '0;
      end
      bnmp_pkg::ST_MUL: begin
        p_q <= prod[SW-1:0];
      end
      bnmp_pkg::ST_PREP: begin
        neg_q   <= p_q[SW-1] ^ denom_c[PW-1];
        zero_q  <= denom_c == '0;
        dvd     <= p_q[SW-1] ? SW'(-p_q) : SW'(p_q);
        dsr     <= denom_c[PW-1] ? PW'(-denom_c) : PW'(denom_c);
        rem     <= '0;
        div_cnt <= '0;
        rmax_rd <= running_max[ch_q[CH_W-1:0]];
      end
      bnmp_pkg::ST_DIV: begin
        // one restoring step: shift in the next dividend bit, try subtract
        if (trial >= {1'b0, dsr}) begin
          rem <= PW'(trial - {1'b0, dsr});
          dvd <= {dvd[SW-2:0], 1'b1};
        end else begin
          rem <= trial[PW-1:0];
          dvd <= {dvd[SW-2:0], 1'b0};
        end
        div_cnt <= div_cnt + 1'b1;
      end
      bnmp_pkg::ST_POST: begin
        if (post_done) running_max[ch_q[CH_W-1:0]] <= new_max;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == bnmp_pkg::ST_POST && emit_q && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bnmp_pkg::ST_POST && emit_q && out_free) begin
      m_tdata <= {4'b0, ch_q, new_max};
      m_tlast <= last_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    ch_cnt <= bnmp_pkg::CH_CNT_W'(CHANNELS - 1))
    else $error("channel counter out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos_cnt < bnmp_pkg::POS_W'(POSITIONS))
    else $error("position counter out of range");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == bnmp_pkg::ST_DIV &&
     div_cnt == bnmp_pkg::DIV_CNT_W'(bnmp_pkg::DIV_STEPS - 1))
    |=> state == bnmp_pkg::ST_POST)
    else $error("divider did not finish after its last step");

  a_post_emit: assert property (@(posedge clk) disable iff (rst)
    (state == bnmp_pkg::ST_POST && emit_q && out_free) |=> m_tvalid)
    else $error("pooled result lost");

  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tdata[19:16] == bnmp_pkg::CH_CNT_W'(CHANNELS - 1))
    else $error("last beat not on the final channel");
`endif

endmodule

// File: tb/tb_batchnorm_maxpool_int16.sv
// ----------------------------------------------------------------------------
// tb_batchnorm_maxpool_int16
// Self-checking bench for the batch-norm and max-pool block: drives sample
// beats with bursty gaps, stalls the result stream, programs the parameter
// registers between phases, and compares every pooled beat against an
// in-bench model of the normalization and windowed maximum.
// ----------------------------------------------------------------------------
module tb_batchnorm_maxpool_int16;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int USED_POS       = (bnmp_pkg::POSITIONS_DEF / bnmp_pkg::POOL_WINDOW_DEF)
                                  * bnmp_pkg::POOL_WINDOW_DEF;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [bnmp_pkg::SAMPLE_W-1:0] value;
    logic [bnmp_pkg::CH_CNT_W-1:0]        channel;
    logic                                 last;
  } pooled_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [bnmp_pkg::SAMPLE_W-1:0]   s_tdata = '0;    // [15:0] sample
  logic                            s_tuser = 1'b0;  // [0] frame_start
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [bnmp_pkg::TDATA_W-1:0]    m_tdata;         // [15:0] pooled_value, [19:16] channel
  logic                            m_tlast;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [bnmp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [bnmp_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [bnmp_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  batchnorm_maxpool_int16 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // model state
  logic [bnmp_pkg::CFG_DATA_W-1:0]      cfg_regs [8];
  logic [bnmp_pkg::CFG_DATA_W-1:0]      next_cfg [8];
  logic signed [bnmp_pkg::SAMPLE_W-1:0] win_max [bnmp_pkg::CHANNELS_DEF];
  logic [bnmp_pkg::CH_CNT_W-1:0]        chan_cnt = '0;
  logic [bnmp_pkg::POS_W-1:0]           pos_cnt = '0;
  logic [bnmp_pkg::PHASE_W-1:0]         pool_phase = '0;
  pooled_beat_t                         pooled_q [$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int stall_left  = 0;
  int rx_mode     = 0;
  int rx_mode_age = 0;

  initial begin
    cfg_regs[bnmp_pkg::REG_SCALE_LO]  = bnmp_pkg::SCALE_RST;
    cfg_regs[bnmp_pkg::REG_SCALE_HI]  = bnmp_pkg::SCALE_RST;
    cfg_regs[bnmp_pkg::REG_MEAN_LO]   = bnmp_pkg::MEAN_RST;
    cfg_regs[bnmp_pkg::REG_MEAN_HI]   = bnmp_pkg::MEAN_RST;
    cfg_regs[bnmp_pkg::REG_OFFSET_LO] = bnmp_pkg::OFFSET_RST;
    cfg_regs[bnmp_pkg::REG_OFFSET_HI] = bnmp_pkg::OFFSET_RST;
    cfg_regs[bnmp_pkg::REG_DENOM_LO]  = bnmp_pkg::DENOM_RST;
    cfg_regs[bnmp_pkg::REG_DENOM_HI]  = bnmp_pkg::DENOM_RST;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  function automatic logic signed [bnmp_pkg::PARAM_W-1:0] param_of(
    input int                            lo_reg,
    input logic [bnmp_pkg::CH_CNT_W-1:0] ch
  );
    logic [bnmp_pkg::CFG_DATA_W-1:0] word;
    word = cfg_regs[lo_reg + int'(ch[3])];
    return $signed(word[8*ch[2:0] +: bnmp_pkg::PARAM_W]);
  endfunction

  function automatic logic signed [bnmp_pkg::SAMPLE_W-1:0] norm_sample(
    input logic signed [bnmp_pkg::SAMPLE_W-1:0] x,
    input logic [bnmp_pkg::CH_CNT_W-1:0]        ch
  );
    logic signed [bnmp_pkg::PARAM_W-1:0]  mu, gain, bias, dv;
    logic signed [bnmp_pkg::SAMPLE_W-1:0] centered, scaled, v;
    int quo;
    mu   = param_of(bnmp_pkg::REG_MEAN_LO, ch);
    gain = param_of(bnmp_pkg::REG_SCALE_LO, ch);
    bias = param_of(bnmp_pkg::REG_OFFSET_LO, ch);
    dv   = param_of(bnmp_pkg::REG_DENOM_LO, ch);
    centered = x - mu;
    scaled   = gain * centered;
    // -32768 / -1 stays 32768 here and wraps on the offset add
    quo = (dv != 0) ? int'(scaled) / int'(dv) : 0;
    v   = quo + bias;
    return v;
  endfunction

  // advance the model by one accepted sample beat
  task automatic track_sample(input logic [bnmp_pkg::SAMPLE_W-1:0] raw, input logic fs);
    logic signed [bnmp_pkg::SAMPLE_W-1:0] v;
    pooled_beat_t beat;
    if (fs) begin
      chan_cnt   = '0;
      pos_cnt    = '0;
      pool_phase = '0;
    end
    if (pos_cnt < USED_POS) begin
      v = norm_sample($signed(raw), chan_cnt);
      if (pool_phase == 0 || v > win_max[chan_cnt]) win_max[chan_cnt] = v;
      if (pool_phase == bnmp_pkg::POOL_WINDOW_DEF - 1) begin
        beat.value   = win_max[chan_cnt];
        beat.channel = chan_cnt;
        beat.last    = (pos_cnt == USED_POS - 1)
                       && (chan_cnt == bnmp_pkg::CHANNELS_DEF - 1);
        pooled_q.push_back(beat);
      end
    end
    if (chan_cnt == bnmp_pkg::CHANNELS_DEF - 1) begin
      chan_cnt   = '0;
      pool_phase = (pool_phase == bnmp_pkg::POOL_WINDOW_DEF - 1) ? '0 : pool_phase + 1'b1;
      pos_cnt    = pos_cnt + 1'b1;
      if (pos_cnt >= bnmp_pkg::POSITIONS_DEF) begin
        pos_cnt    = '0;
        pool_phase = '0;
      end
    end else begin
      chan_cnt = chan_cnt + 1'b1;
    end
  endtask

  task automatic send_sample(input logic [bnmp_pkg::SAMPLE_W-1:0] smp, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 30) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    track_sample(smp, fs);
  endtask

  // hold the input until every pooled beat is back and the pipe is empty
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [bnmp_pkg::CFG_DATA_W-1:0] val);
    logic [bnmp_pkg::CFG_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bnmp_pkg::CFG_ADDR_W'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_regs[idx] = val;
    // read back from the same address
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== val)
      note_mismatch($sformatf("reg %0d readback: expected %h got %h", idx, val, rd));
  endtask

  task automatic load_params();
    for (int r = bnmp_pkg::REG_SCALE_LO; r <= bnmp_pkg::REG_DENOM_HI; r++)
      write_reg(r, next_cfg[r]);
  endtask

  function automatic logic [bnmp_pkg::CFG_DATA_W-1:0] pick_param_word();
    logic [bnmp_pkg::CFG_DATA_W-1:0] w;
    logic [7:0] corners [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    for (int b = 0; b < 8; b++)
      w[8*b +: 8] = ($urandom_range(0, 3) == 0) ? corners[$urandom_range(0, 4)]
                                                : 8'($urandom);
    return w;
  endfunction

  function automatic logic [bnmp_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // every parameter extreme in one window: zero and -1 divisors, +-127/-128
  // scales and means, and -32768 / -1 on channel 1
  task automatic test_directed_window();
    next_cfg[bnmp_pkg::REG_SCALE_LO]  = 64'h01_10_FD_03_80_7F_FF_01;
    next_cfg[bnmp_pkg::REG_SCALE_HI]  = 64'h80_7F_02_FE_05_01_FF_40;
    next_cfg[bnmp_pkg::REG_MEAN_LO]   = 64'hF0_10_FF_01_80_7F_00_00;
    next_cfg[bnmp_pkg::REG_MEAN_HI]   = 64'h7F_80_00_11_22_EE_00_01;
    next_cfg[bnmp_pkg::REG_OFFSET_LO] = 64'h80_7F_FF_01_00_80_7F_00;
    next_cfg[bnmp_pkg::REG_OFFSET_HI] = 64'h7F_80_00_05_FB_00_01_80;
    next_cfg[bnmp_pkg::REG_DENOM_LO]  = 64'h00_FD_03_01_80_7F_FF_00;
    next_cfg[bnmp_pkg::REG_DENOM_HI]  = 64'h80_7F_FF_01_00_07_F9_02;
    load_params();
    for (int ch = 0; ch < bnmp_pkg::CHANNELS_DEF; ch++) send_sample(16'h8000, ch == 0);
    for (int ch = 0; ch < bnmp_pkg::CHANNELS_DEF; ch++) send_sample(16'h7FFF, 1'b0);
    for (int ch = 0; ch < bnmp_pkg::CHANNELS_DEF; ch++)
      send_sample(ch[0] ? 16'hFFFF : 16'h0000, 1'b0);
  endtask

  // frame start in the middle of a window drops the partial window
  task automatic test_midframe_restart();
    for (int i = 0; i < 40; i++) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    for (int i = 0; i < 60; i++) send_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      settle_idle();
      for (int r = bnmp_pkg::REG_SCALE_LO; r <= bnmp_pkg::REG_DENOM_HI; r++) begin
        case (ph)
          0: next_cfg[r] = 64'h7F7F_7F7F_7F7F_7F7F;
          1: next_cfg[r] = 64'h8080_8080_8080_8080;
          2: next_cfg[r] = 64'h0;
          3: next_cfg[r] = 64'hFFFF_FFFF_FFFF_FFFF;
          default: next_cfg[r] = pick_param_word();
        endcase
      end
      load_params();
      gaps_on = (ph % 3 != 1);
      for (int i = 0; i < 88; i++) begin
        if (chan_cnt == 0 && $urandom_range(0, 199) == 0)
          send_sample(pick_sample(), 1'b1);
        else if ($urandom_range(0, 149) == 0)
          send_sample(pick_sample(), 1'b1);
        else
          send_sample(pick_sample(), 1'b0);
      end
    end
    gaps_on = 1'b1;
  endtask

  // result side: stall pattern changes mode every so often
  always @(posedge clk) begin
    if (rx_mode_age == 1500) begin
      rx_mode_age <= 0;
      rx_mode     <= $urandom_range(0, 2);
    end else begin
      rx_mode_age <= rx_mode_age + 1;
    end
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      case (rx_mode)
        1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(0, 4);
        2: if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(10, 80);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    pooled_beat_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.value   = m_tdata[15:0];
      got.channel = m_tdata[19:16];
      got.last    = m_tlast;
      if (pooled_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: value %0d ch %0d last %0b",
                                got.value, got.channel, got.last));
      end else begin
        want = pooled_q.pop_front();
        if (got !== want)
          note_mismatch($sformatf(
            "beat mismatch: expected value %0d ch %0d last %0b, got value %0d ch %0d last %0b",
            want.value, want.channel, want.last, got.value, got.channel, got.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_window();
    test_midframe_restart();
    test_random_traffic();
    settle_idle();
    if (mismatches == 0 && pooled_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
